@@ sv/mprs_pkg.sv @@
// types, constants and helpers shared by the meter poll retry sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package mprs_pkg;

  localparam int RX_DEPTH = 64;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);

  localparam logic [15:0] POLL_RST  = 16'd1000;
  localparam logic [11:0] WAIT_RST  = 12'd100;
  localparam logic [3:0]  RETRY_RST = 4'd5;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [1:0] REG_POLL  = 2'd0;
  localparam logic [1:0] REG_WAIT  = 2'd1;
  localparam logic [1:0] REG_RETRY = 2'd2;

  localparam logic [RX_AW-1:0] ADDR_VEXP = RX_AW'(7);
  localparam logic [RX_AW-1:0] ADDR_CEXP = RX_AW'(8);
  localparam logic [RX_AW-1:0] ADDR_PEXP = RX_AW'(9);

  localparam logic [3:0] Q_LAST     = 4'd15;
  localparam logic [3:0] Q_CURRENT  = 4'd3;
  localparam logic [3:0] Q_POWER    = 4'd6;
  localparam logic [3:0] Q_PF       = 4'd12;

  localparam logic signed [7:0] EXP_FIXED = -8'sd2;

  typedef enum logic [2:0] {
    ACT_REQ_SCALE  = 3'd0,
    ACT_REQ_VALUES = 3'd1,
    ACT_VALUE      = 3'd2,
    ACT_ERR_SCALE  = 3'd3,
    ACT_ERR_VALUES = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SCALE  = 2'd1,
    PH_VALUES = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_EXP0,
    DP_EXP1,
    DP_EXP2,
    DP_EXP3,
    DP_VLO,
    DP_VHI,
    DP_VCAP,
    DP_VEMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP0,
    ST_EXP1,
    ST_EXP2,
    ST_EXP3,
    ST_VLO,
    ST_VHI,
    ST_VCAP,
    ST_VOUT
  } ctl_state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [3:0]        quantity;
    logic [15:0]       raw_value;
    logic signed [7:0] decimal_exponent;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] poll_period;
    logic [11:0] reply_wait;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic out_free;
    logic go_exp;
    logic go_values;
    logic last_val;
  } dp_status_t;

  // buffer position of the low byte of value result k
  function automatic logic [5:0] val_lo_addr(input logic [3:0] k);
    logic [5:0] a;
    if (k < Q_PF) begin
      a = 6'd6 + {1'b0, k, 1'b0};
    end else if (k == Q_LAST) begin
      a = 6'd33;
    end else begin
      a = 6'd18 + {2'b00, k};
    end
    return a;
  endfunction

endpackage

`default_nettype wire

@@ sv/mprs_ctrl.sv @@
// controller state machine: item acceptance, exponent load and value emission steps
// depends on mprs_pkg; drives the datapath through dp_op_t commands
`default_nettype none

module mprs_ctrl
  import mprs_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_op_t     op
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.out_free) begin
          if (sts.go_exp) begin
            state_nxt = ST_EXP0;
          end else if (sts.go_values) begin
            state_nxt = ST_VLO;
          end
        end
      end
      ST_EXP0: state_nxt = ST_EXP1;
      ST_EXP1: state_nxt = ST_EXP2;
      ST_EXP2: state_nxt = ST_EXP3;
      ST_EXP3: state_nxt = ST_IDLE;
      ST_VLO:  state_nxt = ST_VHI;
      ST_VHI:  state_nxt = ST_VCAP;
      ST_VCAP: state_nxt = ST_VOUT;
      ST_VOUT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_val ? ST_IDLE : ST_VLO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    op       = DP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_stall = !sts.out_free;
        op       = (in_valid && sts.out_free) ? DP_ACCEPT : DP_NONE;
      end
      ST_EXP0: op = DP_EXP0;
      ST_EXP1: op = DP_EXP1;
      ST_EXP2: op = DP_EXP2;
      ST_EXP3: op = DP_EXP3;
      ST_VLO:  op = DP_VLO;
      ST_VHI:  op = DP_VHI;
      ST_VCAP: op = DP_VCAP;
      ST_VOUT: op = sts.out_free ? DP_VEMIT : DP_NONE;
      default: op = DP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mprs_datapath.sv @@
// datapath: poll state, reply window timing, reply buffer and output register
// depends on mprs_pkg; commanded by mprs_ctrl
`default_nettype none

module mprs_datapath
  import mprs_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  cfg_t       cfg,
  input  in_item_t   in_data,
  input  dp_op_t     op,
  output dp_status_t sts,
  output logic       out_valid,
  input  wire        out_stall,
  output out_item_t  out_data
);

  phase_t           phase_r, phase_nxt;
  logic             waiting_r, waiting_nxt;
  logic [3:0]       attempts_r, attempts_nxt;
  logic [11:0]      timer_r, timer_nxt;
  logic [15:0]      since_r, since_nxt;
  logic [RX_CW-1:0] bcnt_r, bcnt_nxt;
  logic [7:0]       vexp_r, vexp_nxt;
  logic [7:0]       cexp_r, cexp_nxt;
  logic [7:0]       pexp_r, pexp_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [7:0]        mem [RX_DEPTH];
  logic [RX_DEPTH-1:0] vld_r;
  logic [7:0]        rd_data_r;
  logic              rd_vld_r;
  logic [7:0]        rd_byte;
  logic [RX_AW-1:0]  rd_addr;
  logic [RX_AW-1:0]  lo_addr;

  logic        is_byte, wr_ok;
  logic [15:0] since_inc;
  logic        busy, closed, good;
  logic        tk_poll, tk_resend, tk_count, tk_retry, tk_fail, go_exp, go_values;
  logic        out_free, pf;
  logic [7:0]  val_exp;

  assign is_byte   = (op == DP_ACCEPT) && (in_data.command == CMD_BYTE);
  assign wr_ok     = waiting_r && (phase_r != PH_IDLE) && (bcnt_r < RX_CW'(RX_DEPTH));
  assign since_inc = (since_r == 16'hFFFF) ? since_r : since_r + 16'd1;

  assign busy      = phase_r != PH_IDLE;
  assign closed    = busy && waiting_r && !(timer_r < cfg.reply_wait);
  assign good      = closed && (bcnt_r != '0);
  assign tk_poll   = !busy && (since_inc >= cfg.poll_period);
  assign tk_resend = busy && !waiting_r;
  assign tk_count  = busy && waiting_r && (timer_r < cfg.reply_wait);
  assign go_exp    = good && (phase_r == PH_SCALE);
  assign go_values = good && (phase_r == PH_VALUES);
  assign tk_retry  = closed && !good && (attempts_r < cfg.retry_limit);
  assign tk_fail   = closed && !good && !(attempts_r < cfg.retry_limit);

  assign out_free  = !out_valid_r || !out_stall;

  assign sts.out_free  = out_free;
  assign sts.go_exp    = (in_data.command == CMD_TICK) && go_exp;
  assign sts.go_values = (in_data.command == CMD_TICK) && go_values;
  assign sts.last_val  = k_r == Q_LAST;

  assign lo_addr = RX_AW'(val_lo_addr(k_r));
  assign rd_byte = rd_vld_r ? rd_data_r : 8'h00;
  assign pf      = (k_r >= Q_PF) && (k_r != Q_LAST);

  always_comb begin
    if (k_r < Q_CURRENT) begin
      val_exp = vexp_r;
    end else if (k_r < Q_POWER) begin
      val_exp = cexp_r;
    end else if (k_r < Q_PF) begin
      val_exp = pexp_r;
    end else begin
      val_exp = EXP_FIXED;
    end
  end

  always_comb begin
    case (op)
      DP_EXP0: rd_addr = ADDR_VEXP;
      DP_EXP1: rd_addr = ADDR_CEXP;
      DP_EXP2: rd_addr = ADDR_PEXP;
      DP_VHI:  rd_addr = lo_addr + RX_AW'(1);
      default: rd_addr = lo_addr;
    endcase
  end

  // reply buffer with registered read
  always_ff @(posedge clk) begin
    if (is_byte && wr_ok) begin
      mem[bcnt_r[RX_AW-1:0]] <= in_data.rx_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (is_byte && wr_ok) begin
        vld_r[bcnt_r[RX_AW-1:0]] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    waiting_nxt   = waiting_r;
    attempts_nxt  = attempts_r;
    timer_nxt     = timer_r;
    since_nxt     = since_r;
    bcnt_nxt      = bcnt_r;
    vexp_nxt      = vexp_r;
    cexp_nxt      = cexp_r;
    pexp_nxt      = pexp_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (op)
      DP_ACCEPT: begin
        if (is_byte) begin
          if (wr_ok) begin
            bcnt_nxt = bcnt_r + RX_CW'(1);
          end
        end else begin
          since_nxt = since_inc;
          out_data_nxt = '0;
          out_data_nxt.last = 1'b1;
          if (tk_poll) begin
            phase_nxt     = PH_SCALE;
            attempts_nxt  = '0;
            bcnt_nxt      = '0;
            waiting_nxt   = 1'b1;
            timer_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt.action = ACT_REQ_SCALE;
          end else if (tk_resend || tk_retry) begin
            if (tk_retry) begin
              attempts_nxt = attempts_r + 4'd1;
            end
            waiting_nxt   = 1'b1;
            timer_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt.action = (phase_r == PH_SCALE) ? ACT_REQ_SCALE : ACT_REQ_VALUES;
          end else if (tk_count) begin
            timer_nxt = timer_r + 12'd1;
          end else if (go_exp) begin
            phase_nxt     = PH_VALUES;
            attempts_nxt  = '0;
            bcnt_nxt      = '0;
            waiting_nxt   = 1'b1;
            timer_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt.action = ACT_REQ_VALUES;
          end else if (go_values) begin
            since_nxt   = '0;
            phase_nxt   = PH_IDLE;
            waiting_nxt = 1'b0;
            k_nxt       = '0;
          end else if (tk_fail) begin
            phase_nxt     = PH_IDLE;
            waiting_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt.action = (phase_r == PH_SCALE) ? ACT_ERR_SCALE : ACT_ERR_VALUES;
          end
        end
      end
      DP_EXP1: vexp_nxt = rd_byte;
      DP_EXP2: cexp_nxt = rd_byte;
      DP_EXP3: pexp_nxt = rd_byte;
      DP_VHI:  lo_nxt   = rd_byte;
      DP_VCAP: hi_nxt   = rd_byte;
      DP_VEMIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.action           = ACT_VALUE;
        out_data_nxt.quantity         = k_r;
        out_data_nxt.raw_value        = pf ? {8'h00, lo_r} : {hi_r, lo_r};
        out_data_nxt.decimal_exponent = val_exp;
        out_data_nxt.last             = k_r == Q_LAST;
        k_nxt = k_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      waiting_r   <= 1'b0;
      attempts_r  <= '0;
      timer_r     <= '0;
      since_r     <= '0;
      bcnt_r      <= '0;
      vexp_r      <= '0;
      cexp_r      <= '0;
      pexp_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      waiting_r   <= waiting_nxt;
      attempts_r  <= attempts_nxt;
      timer_r     <= timer_nxt;
      since_r     <= since_nxt;
      bcnt_r      <= bcnt_nxt;
      vexp_r      <= vexp_nxt;
      cexp_r      <= cexp_nxt;
      pexp_r      <= pexp_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/meter_poll_retry_sequencer_unit.sv @@
// top level of the meter poll retry sequencer: register port, controller and datapath
// depends on mprs_pkg, mprs_ctrl and mprs_datapath
//
// Polling master for a three-phase meter. Each input transaction is a millisecond tick
// or a received byte. A byte, and a tick that sends a request, times the reply window or
// reports an error, is taken as soon as the output register is free. A tick that closes
// a good scale reply puts out the values request at once and then stalls the input in
// ST_EXP0 to ST_EXP3 while the three exponents are read over the reply buffer's single
// read port. A tick that closes a good values reply emits sixteen value results, each
// through ST_VLO, ST_VHI, ST_VCAP and ST_VOUT (two buffer reads and the output load; an
// output stall holds ST_VOUT). The output register holds one result. Registers: poll
// period at 0x0, reply wait at 0x4, retry limit at 0x8; write only while idle.
`default_nettype none

module meter_poll_retry_sequencer_unit
  import mprs_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_stall,
  output out_item_t  out_data,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  cfg_t       cfg_r, cfg_nxt;
  dp_status_t sts;
  dp_op_t     op;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_POLL:  cfg_nxt.poll_period = pwdata[15:0];
        REG_WAIT:  cfg_nxt.reply_wait  = pwdata[11:0];
        REG_RETRY: cfg_nxt.retry_limit = pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_period <= POLL_RST;
      cfg_r.reply_wait  <= WAIT_RST;
      cfg_r.retry_limit <= RETRY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POLL:  prdata = {16'h0000, cfg_r.poll_period};
      REG_WAIT:  prdata = {20'h00000, cfg_r.reply_wait};
      REG_RETRY: prdata = {28'h0000000, cfg_r.retry_limit};
      default:   prdata = '0;
    endcase
  end

  mprs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  mprs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .op        (op),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ bench/tb_meter_poll_retry_sequencer_unit.sv @@
// testbench for meter_poll_retry_sequencer_unit: directed polls, retries, error and overflow
// cases, then random tick and reply streams checked against a built-in predictor
// depends on mprs_pkg and the RTL of the unit
module tb_meter_poll_retry_sequencer_unit;
  import mprs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam logic [79:0] SCALE_REPLY = {
    8'hFF, 8'h7F, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00
  };

  class poll_scoreboard;
    logic [15:0] poll_period;
    logic [11:0] reply_wait;
    logic [3:0]  retry_limit;
    phase_t      phase;
    bit          waiting;
    bit          new_window;
    logic [3:0]  attempts;
    logic [11:0] window_timer;
    logic [15:0] since_good;
    int unsigned byte_count;
    logic [7:0]  reply_buf [RX_DEPTH];
    logic [7:0]  volt_exp;
    logic [7:0]  curr_exp;
    logic [7:0]  pow_exp;
    out_item_t   results_due [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned readings;
    int unsigned error_results;
    int unsigned retries;

    function new();
      poll_period = POLL_RST;
      reply_wait = WAIT_RST;
      retry_limit = RETRY_RST;
      phase = PH_IDLE;
      waiting = 1'b0;
      new_window = 1'b0;
      attempts = '0;
      window_timer = '0;
      since_good = '0;
      byte_count = 0;
      foreach (reply_buf[i]) reply_buf[i] = 8'h00;
      volt_exp = '0;
      curr_exp = '0;
      pow_exp = '0;
      mismatches = 0;
      results_seen = 0;
      readings = 0;
      error_results = 0;
      retries = 0;
    endfunction

    task report(string msg);
      if (mismatches < 20) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_POLL: poll_period = val[15:0];
        REG_WAIT: reply_wait = val[11:0];
        REG_RETRY: retry_limit = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_POLL: return {16'h0, poll_period};
        REG_WAIT: return {20'h0, reply_wait};
        default: return {28'h0, retry_limit};
      endcase
    endfunction

    function void queue_result(act_t act, logic [3:0] qty, logic [15:0] raw, logic [7:0] ex);
      out_item_t r;
      r.action = act;
      r.quantity = qty;
      r.raw_value = raw;
      r.decimal_exponent = ex;
      r.last = 1'b0;
      results_due.push_back(r);
    endfunction

    function void open_request();
      queue_result(phase == PH_SCALE ? ACT_REQ_SCALE : ACT_REQ_VALUES, 4'd0, 16'd0, 8'd0);
      waiting = 1'b1;
      window_timer = '0;
      new_window = 1'b1;
    endfunction

    function void queue_readings();
      logic [7:0] ex;
      for (int k = 0; k < 12; k++) begin
        ex = k < 3 ? volt_exp : (k < 6 ? curr_exp : pow_exp);
        queue_result(ACT_VALUE, 4'(k), {reply_buf[7 + 2 * k], reply_buf[6 + 2 * k]}, ex);
      end
      for (int k = 0; k < 3; k++)
        queue_result(ACT_VALUE, Q_PF + 4'(k), {8'h00, reply_buf[30 + k]}, EXP_FIXED);
      queue_result(ACT_VALUE, Q_LAST, {reply_buf[34], reply_buf[33]}, EXP_FIXED);
    endfunction

    // predicts the results of one accepted transaction
    function void take_input(in_item_t it);
      int unsigned before_n;
      out_item_t tail;
      before_n = results_due.size();
      new_window = 1'b0;
      if (it.command == CMD_BYTE) begin
        if (waiting && phase != PH_IDLE && byte_count < RX_DEPTH) begin
          reply_buf[byte_count] = it.rx_byte;
          byte_count++;
        end
        return;
      end
      if (since_good != 16'hFFFF) since_good++;
      if (phase == PH_IDLE) begin
        if (since_good >= poll_period) begin
          phase = PH_SCALE;
          attempts = '0;
          byte_count = 0;
          open_request();
        end
      end else if (!waiting) begin
        open_request();
      end else if (window_timer < reply_wait) begin
        window_timer++;
      end else if (byte_count > 0) begin
        if (phase == PH_SCALE) begin
          volt_exp = reply_buf[7];
          curr_exp = reply_buf[8];
          pow_exp = reply_buf[9];
          phase = PH_VALUES;
          attempts = '0;
          byte_count = 0;
          open_request();
        end else begin
          queue_readings();
          readings++;
          since_good = '0;
          phase = PH_IDLE;
          waiting = 1'b0;
        end
      end else if (attempts < retry_limit) begin
        attempts++;
        retries++;
        open_request();
      end else begin
        queue_result(phase == PH_SCALE ? ACT_ERR_SCALE : ACT_ERR_VALUES, 4'd0, 16'd0, 8'd0);
        error_results++;
        phase = PH_IDLE;
        waiting = 1'b0;
      end
      if (results_due.size() > before_n) begin
        tail = results_due.pop_back();
        tail.last = 1'b1;
        results_due.push_back(tail);
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (results_due.size() == 0) begin
        report($sformatf("result %0d (action %0d) arrived with none expected",
                         results_seen, got.action));
        return;
      end
      want = results_due.pop_front();
      if (got.action !== want.action)
        report($sformatf("result %0d action %0d, expected %0d",
                         results_seen, got.action, want.action));
      if (got.quantity !== want.quantity)
        report($sformatf("result %0d quantity %0d, expected %0d",
                         results_seen, got.quantity, want.quantity));
      if (got.raw_value !== want.raw_value)
        report($sformatf("result %0d raw_value %h, expected %h",
                         results_seen, got.raw_value, want.raw_value));
      if (got.decimal_exponent !== want.decimal_exponent)
        report($sformatf("result %0d decimal_exponent %0d, expected %0d",
                         results_seen, got.decimal_exponent, want.decimal_exponent));
      if (got.last !== want.last)
        report($sformatf("result %0d last %b, expected %b", results_seen, got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  poll_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  meter_poll_retry_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] data,
                           output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_register(logic [1:0] idx);
    logic [31:0] rd;
    apb_cycle(1'b0, idx, 32'h0, rd);
    if (rd !== sb.reg_value(idx))
      sb.report($sformatf("register %0d reads %h, expected %h", idx, rd, sb.reg_value(idx)));
  endtask

  task automatic program_register(logic [1:0] idx, logic [31:0] val);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, val, rd);
    sb.set_register(idx, val);
    check_register(idx);
  endtask

  task automatic configure(logic [15:0] poll, logic [11:0] wait_ms, logic [3:0] retry);
    program_register(REG_POLL, {16'h0, poll});
    program_register(REG_WAIT, {20'h0, wait_ms});
    program_register(REG_RETRY, {28'h0, retry});
  endtask

  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_input(it);
    items_sent++;
  endtask

  task automatic tick();
    in_item_t it;
    it.command = CMD_TICK;
    it.rx_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic rx_byte_item(logic [7:0] b);
    in_item_t it;
    it.command = CMD_BYTE;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed replies: bytes inside windows, with empty, short and overlong replies
  task automatic reply_stream(int unsigned n);
    in_item_t it;
    int unsigned target;
    int unsigned in_window;
    int unsigned r;
    target = 0;
    in_window = 0;
    repeat (n) begin
      if ($urandom_range(0, 99) < 8) begin
        it.command = 1'($urandom);
        it.rx_byte = 8'($urandom);
      end else if (sb.waiting && in_window < target && $urandom_range(0, 99) < 85) begin
        it.command = CMD_BYTE;
        it.rx_byte = 8'($urandom);
      end else begin
        it.command = CMD_TICK;
        it.rx_byte = 8'($urandom);
      end
      send_item(it);
      if (it.command == CMD_BYTE) in_window++;
      if (sb.new_window) begin
        in_window = 0;
        r = $urandom_range(0, 99);
        if (r < 20) target = 0;
        else if (r < 30) target = $urandom_range(37, 75);
        else target = $urandom_range(1, 36);
      end
    end
  endtask

  task automatic random_phase(int unsigned sender_idle, int unsigned receiver_stall,
                              int unsigned n);
    wait_quiet();
    configure(16'($urandom_range(1, 12)), 12'($urandom_range(1, 8)),
              4'($urandom_range(0, 3)));
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    reply_stream(n);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    check_register(REG_POLL);
    check_register(REG_WAIT);
    check_register(REG_RETRY);

    // zero-length window, exponents at the signed extremes, short values reply
    configure(16'd1, 12'd0, 4'd0);
    rx_byte_item(8'hAA);
    tick();
    for (int i = 0; i < 10; i++) rx_byte_item(SCALE_REPLY[8 * i +: 8]);
    tick();
    rx_byte_item(8'hFF);
    rx_byte_item(8'h00);
    tick();
    tick();
    tick();
    tick();
    tick();

    // register extremes, then the longest run of retries ending in an error
    wait_quiet();
    configure(16'hFFFF, 12'hFFF, 4'hF);
    configure(16'd1, 12'd0, 4'hF);
    while (sb.phase == PH_IDLE) tick();
    while (sb.phase != PH_IDLE) tick();
    tick();

    // bytes outside any window, then an empty scale window ending in an error
    wait_quiet();
    configure(16'd1, 12'd2, 4'd0);
    for (int i = 0; i < 70; i++) rx_byte_item(8'($urandom));
    while (sb.phase == PH_SCALE) tick();
    while (sb.phase != PH_IDLE) tick();

    random_phase(0, 0, 20);
    random_phase(66, 0, 20);
    random_phase(0, 66, 20);
    random_phase(23, 23, 20);

    // long receiver hold-off while input keeps coming, then a full drain and more traffic
    wait_quiet();
    configure(16'd1, 12'd2, 4'd1);
    idle_pct = 0;
    stall_pct = 30;
    @(posedge clk);
    hold_len = 400;
    hold_token++;
    reply_stream(40);
    wait_quiet();
    reply_stream(20);

    wait_quiet();
    if (sb.results_due.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.results_due.size()));
    $display("sent %0d input transactions, checked %0d results: %0d readings,",
             items_sent, sb.results_seen, sb.readings);
    $display("%0d errors, %0d retries; covered stray, short and overflowing replies,",
             sb.error_results, sb.retries);
    $display("long retry runs, register extremes and a long output hold-off");
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
